// File: rtl/msns_pkg.sv
// Shared types, codes and Morse tables for the serial number sender.
// Used by msns_counter, msns_keyer and morse_serial_number_sender_core.
`default_nettype none

package msns_pkg;

  // default sizes
  localparam int MAX_DIGITS_DEF = 5;
  localparam int COUNT_BITS_DEF = 16;

  // stream payload widths
  localparam int ACTION_W = 3;
  localparam int TIME_W   = 32;
  localparam int TICKS_W  = 16;
  localparam int SER_W    = 16;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 24;

  // configuration register indexes
  localparam logic [1:0] REG_DOT  = 2'd0;
  localparam logic [1:0] REG_DASH = 2'd1;
  localparam logic [1:0] REG_PTT  = 2'd2;

  localparam logic [TICKS_W-1:0] DOT_RESET  = 16'd60;
  localparam logic [TICKS_W-1:0] DASH_RESET = 16'd180;
  localparam logic [TICKS_W-1:0] PTT_RESET  = 16'd0;

  // request actions
  localparam logic [ACTION_W-1:0] ACT_TICK      = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_START_CUT = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_START_DIG = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_ARM_DEC   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_APPLY     = 3'd4;

  // element_started codes
  localparam logic [1:0] START_NONE = 2'd0;
  localparam logic [1:0] START_DIT  = 2'd1;
  localparam logic [1:0] START_DAH  = 2'd2;

  typedef logic [3:0] digit_t;

  typedef enum logic [2:0] {
    PHASE_UP  = 3'b001,
    PHASE_DIT = 3'b010,
    PHASE_DAH = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd3
  } step_t;

  // keyer to counter commands
  typedef struct packed {
    logic arm_inc;
    logic arm_dec;
    logic apply;
  } cnt_cmd_t;

  // Morse character codes: element count in [14:12], elements from bit 0, 1 is dah
  localparam logic [15:0] CODE_T = 16'h1001;
  localparam logic [15:0] CODE_N = 16'h2001;

  function automatic logic [15:0] digit_code(input digit_t d);
    logic [15:0] c;
    unique case (d)
      4'd0:    c = 16'h501f;
      4'd1:    c = 16'h501e;
      4'd2:    c = 16'h501c;
      4'd3:    c = 16'h5018;
      4'd4:    c = 16'h5010;
      4'd5:    c = 16'h5000;
      4'd6:    c = 16'h5001;
      4'd7:    c = 16'h5003;
      4'd8:    c = 16'h5007;
      4'd9:    c = 16'h500f;
      default: c = 16'h501f;
    endcase
    return c;
  endfunction

  // power of ten, evaluated at elaboration
  function automatic logic [63:0] pow10(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// File: rtl/msns_counter.sv
// Serial count in binary with a shadow BCD copy of its low decimal digits.
// Depends on msns_pkg; driven by command struct from msns_keyer.
`default_nettype none

module msns_counter import msns_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               fire,
  input  wire cnt_cmd_t                           cmd,
  output logic [COUNT_BITS-1:0]                   count_next,
  output logic [MAX_DIGITS-1:0][3:0]              bcd,
  output logic [$clog2(MAX_DIGITS+1)-1:0]         ndig
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam logic [63:0] LIMIT = pow10(MAX_DIGITS);
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0]       count;
  logic [MAX_DIGITS-1:0][3:0]  bcd_next;
  step_t                       step;
  step_t                       step_next;

  // leading digit search gives the number of digits to send
  always_comb begin
    ndig = CNT_W'(1);
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[i] != 4'd0) begin
        ndig = CNT_W'(i + 1);
      end
    end
    if ({{(64-COUNT_BITS){1'b0}}, count} >= LIMIT) begin
      ndig = CNT_W'(MAX_DIGITS);
    end
  end

  // armed step and saturating update of both count forms
  always_comb begin
    logic c;
    count_next = count;
    bcd_next   = bcd;
    step_next  = step;
    c          = 1'b1;
    if (cmd.apply) begin
      step_next = STEP_NONE;
      if (step == STEP_UP && count != CMAX) begin
        count_next = count + COUNT_BITS'(1);
        for (int i = 0; i < MAX_DIGITS; i++) begin
          if (c) begin
            if (bcd[i] == 4'd9) begin
              bcd_next[i] = 4'd0;
            end else begin
              bcd_next[i] = bcd[i] + 4'd1;
              c = 1'b0;
            end
          end
        end
      end else if (step == STEP_DOWN && count != '0) begin
        count_next = count - COUNT_BITS'(1);
        for (int i = 0; i < MAX_DIGITS; i++) begin
          if (c) begin
            if (bcd[i] == 4'd0) begin
              bcd_next[i] = 4'd9;
            end else begin
              bcd_next[i] = bcd[i] - 4'd1;
              c = 1'b0;
            end
          end
        end
      end
    end else if (cmd.arm_inc) begin
      step_next = STEP_UP;
    end else if (cmd.arm_dec) begin
      step_next = STEP_DOWN;
    end
  end

  // count state, reset to one
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= COUNT_BITS'(1);
      bcd    <= (MAX_DIGITS*4)'(1);
      step   <= STEP_NONE;
    end else if (fire) begin
      count  <= count_next;
      bcd    <= bcd_next;
      step   <= step_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/msns_keyer.sv
// Morse element sequencer: digit snapshot, element timing and event reporting.
// Depends on msns_pkg; reads decimal digits from msns_counter.
`default_nettype none

module msns_keyer import msns_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               fire,
  input  wire logic [ACTION_W-1:0]                action,
  input  wire logic [TIME_W-1:0]                  now,
  input  wire logic [TICKS_W-1:0]                 dot_ticks,
  input  wire logic [TICKS_W-1:0]                 dash_ticks,
  input  wire logic [TICKS_W-1:0]                 ptt_ticks,
  input  wire logic [MAX_DIGITS-1:0][3:0]         bcd,
  input  wire logic [$clog2(MAX_DIGITS+1)-1:0]    ndig,
  output cnt_cmd_t                                cmd,
  output logic                                    key_down,
  output logic [1:0]                              started,
  output logic [1:0]                              spaces,
  output logic                                    idle
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic                        sending, sending_next;
  logic                        cut, cut_next;
  phase_t                      phase, phase_next;
  logic [4:0]                  bits, bits_next;
  logic [2:0]                  el_left, el_left_next;
  logic [TIME_W-1:0]           net, net_next;
  logic                        load, load_next;
  logic [MAX_DIGITS-1:0][3:0]  snap, snap_next;
  logic [IDX_W-1:0]            pos, pos_next;
  logic [CNT_W-1:0]            chars, chars_next;

  logic [TICKS_W:0] dit_len;
  logic [TICKS_W:0] dah_len;

  assign dit_len = {1'b0, dot_ticks} + {1'b0, ptt_ticks};
  assign dah_len = {1'b0, dash_ticks} + {1'b0, ptt_ticks};

  // next state for one request
  always_comb begin
    digit_t      d;
    logic [15:0] code;
    sending_next = sending;
    cut_next     = cut;
    phase_next   = phase;
    bits_next    = bits;
    el_left_next = el_left;
    net_next     = net;
    load_next    = load;
    snap_next    = snap;
    pos_next     = pos;
    chars_next   = chars;
    cmd          = '0;
    started      = START_NONE;
    spaces       = 2'd0;
    d            = '0;
    code         = '0;

    if (!sending) begin
      // start a send from the current digits, or arm a decrement
      if (action == ACT_START_CUT || action == ACT_START_DIG) begin
        sending_next = 1'b1;
        cut_next     = (action == ACT_START_CUT);
        snap_next    = bcd;
        pos_next     = IDX_W'(ndig - CNT_W'(1));
        chars_next   = ndig;
        load_next    = 1'b1;
        net_next     = '0;
        phase_next   = PHASE_UP;
        bits_next    = '0;
        el_left_next = '0;
        cmd.arm_inc  = 1'b1;
      end else if (action == ACT_ARM_DEC) begin
        cmd.arm_dec  = 1'b1;
      end
    end else if (!load && now >= net) begin
      // timed element event
      if (phase == PHASE_UP) begin
        if (bits[0]) begin
          phase_next = PHASE_DAH;
          net_next   = now + TIME_W'(dah_len);
          started    = START_DAH;
        end else begin
          phase_next = PHASE_DIT;
          net_next   = now + TIME_W'(dit_len);
          started    = START_DIT;
        end
      end else begin
        phase_next = PHASE_UP;
        if (el_left > 3'd1) begin
          el_left_next = el_left - 3'd1;
          bits_next    = bits >> 1;
          net_next     = now + TIME_W'(dot_ticks);
        end else begin
          el_left_next = '0;
          net_next     = now + TIME_W'(dash_ticks);
          spaces       = 2'd1;
          load_next    = 1'b1;
        end
      end
    end

    // load the next character or finish the message
    if (sending_next && load_next) begin
      load_next = 1'b0;
      if (chars_next != '0) begin
        d = snap_next[pos_next];
        if (cut_next && d == 4'd0) begin
          code = CODE_T;
        end else if (cut_next && d == 4'd9) begin
          code = CODE_N;
        end else begin
          code = digit_code(d);
        end
        el_left_next = code[14:12];
        bits_next    = code[4:0];
        pos_next     = pos_next - IDX_W'(1);
        chars_next   = chars_next - CNT_W'(1);
      end else begin
        sending_next = 1'b0;
        spaces       = spaces + 2'd1;
      end
    end

    cmd.apply = (action == ACT_APPLY);
    key_down  = (phase_next != PHASE_UP);
    idle      = !sending_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      sending <= 1'b0;
      cut     <= 1'b0;
      phase   <= PHASE_UP;
      bits    <= '0;
      el_left <= '0;
      net     <= '0;
      load    <= 1'b0;
      pos     <= '0;
      chars   <= '0;
    end else if (fire) begin
      sending <= sending_next;
      cut     <= cut_next;
      phase   <= phase_next;
      bits    <= bits_next;
      el_left <= el_left_next;
      net     <= net_next;
      load    <= load_next;
      pos     <= pos_next;
      chars   <= chars_next;
    end
  end

  // digit snapshot, written at send start
  always_ff @(posedge clk) begin
    if (fire) begin
      snap <= snap_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/morse_serial_number_sender_core.sv
// A request goes to the input register, its result to the result register.
// Throughput: one request per cycle unless m_tready stalls; the input register,
// the keyer and counter update logic and the result register form a single pass.
// While a result waits, the input register still takes one more request.
// Reset (synchronous, rst high): count 1, no send, registers 60/180/0 ticks.
// Top level: input register, keyer, counter, result register and config regs.
`default_nettype none

module morse_serial_number_sender_core import msns_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // request stream
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [IN_W-1:0]     s_tdata,   // action[2:0], now[34:3], zero pad
  // result stream
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // key_down[0], element_started[2:1], char_spaces[4:3], idle[5],
  // serial_count[21:6], zero pad
  output logic [OUT_W-1:0]         m_tdata,
  // configuration writes
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_addr,
  input  wire logic [TICKS_W-1:0]  cfg_wdata
);

  logic                 v1;
  logic [ACTION_W-1:0]  action1;
  logic [TIME_W-1:0]    now1;
  logic                 adv;
  logic                 fire;

  logic [TICKS_W-1:0] dot_ticks;
  logic [TICKS_W-1:0] dash_ticks;
  logic [TICKS_W-1:0] ptt_ticks;

  cnt_cmd_t                           cmd;
  logic [COUNT_BITS-1:0]              count_next;
  logic [MAX_DIGITS-1:0][3:0]         bcd;
  logic [$clog2(MAX_DIGITS+1)-1:0]    ndig;
  logic                               key_down;
  logic [1:0]                         started;
  logic [1:0]                         spaces;
  logic                               idle;
  logic [SER_W+COUNT_BITS-1:0]        count_ext;

  // handshake: pass when the result slot is free or being drained
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = !v1 || adv;
  assign fire     = v1 && adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tready) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      action1 <= s_tdata[ACTION_W-1:0];
      now1    <= s_tdata[ACTION_W+TIME_W-1:ACTION_W];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_ticks  <= DOT_RESET;
      dash_ticks <= DASH_RESET;
      ptt_ticks  <= PTT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DOT:  dot_ticks  <= cfg_wdata;
        REG_DASH: dash_ticks <= cfg_wdata;
        REG_PTT:  ptt_ticks  <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  msns_keyer #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_keyer (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .action     (action1),
    .now        (now1),
    .dot_ticks  (dot_ticks),
    .dash_ticks (dash_ticks),
    .ptt_ticks  (ptt_ticks),
    .bcd        (bcd),
    .ndig       (ndig),
    .cmd        (cmd),
    .key_down   (key_down),
    .started    (started),
    .spaces     (spaces),
    .idle       (idle)
  );

  msns_counter #(
    .COUNT_BITS (COUNT_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_counter (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .cmd        (cmd),
    .count_next (count_next),
    .bcd        (bcd),
    .ndig       (ndig)
  );

  assign count_ext = {{SER_W{1'b0}}, count_next};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {2'b00, count_ext[SER_W-1:0], idle, spaces, started, key_down};
    end
  end

endmodule

`default_nettype wire
